/* src/mlptw_pkg.sv */
// Package with the constants, state codes and result codes of the page table walker.
`timescale 1ns / 1ps

package mlptw_pkg;

  localparam int LEVEL_COUNT = 4;
  localparam int OFFSET_BITS = 12;
  localparam int FRAME_COUNT = 256;

  localparam int VA_W = 48;
  localparam int PHYS_W = 20;
  localparam int STATUS_W = 2;

  localparam int IDX_BITS = OFFSET_BITS - 3;
  localparam int FRAME_BITS = $clog2(FRAME_COUNT);
  localparam int ENTRY_W = FRAME_BITS + 1;
  localparam int STORE_DEPTH = FRAME_COUNT * (2 ** IDX_BITS);
  localparam int ADDR_W = FRAME_BITS + IDX_BITS;
  localparam int FREE_W = $clog2(FRAME_COUNT + 1);
  localparam int VPN_W = IDX_BITS * LEVEL_COUNT;
  localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FAULT    = 2'd1,
    STATUS_NO_FRAME = 2'd2
  } status_t;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_MAP       = 1'b1
  } opcode_t;

endpackage

/* src/multilevel_page_table_walker.sv */
// Multi-level page table walker with a bump frame allocator and an on-chip entry store.
// A request (opcode, virt_addr) is transferred at a rising edge with start high and busy
// low. A translate walks the levels and returns the frame and page offset as phys_addr,
// or a fault. A map walks the levels and allocates a fresh frame for every invalid
// entry, the data page included; the first map allocates the root table as frame 0.
// Each result appears on phys_addr and status for exactly one cycle with done high.
// The walk reads one entry per level from the store with a registered read,
// so each level passes through S_READ and then S_CHECK: done is registered from the
// last level's S_CHECK and busy falls in that same cycle, so no new request is taken
// while a walk runs. A translate before any map shows its result in the cycle
// right after the request edge and leaves busy low, so the next request can follow at
// once; a fault or an exhausted pool ends the walk at the level where it occurs.
// After reset the block sweeps the whole entry store to zero, one entry per cycle,
// which keeps busy high through all STORE_DEPTH entries (131072 with current sizes).
// The receiver cannot stall: each result is transferred in the cycle it is shown.
`timescale 1ns / 1ps

module multilevel_page_table_walker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               opcode,
  input  logic [mlptw_pkg::VA_W-1:0]         virt_addr,
  output logic                               done,
  output logic [mlptw_pkg::PHYS_W-1:0]       phys_addr,
  output logic [mlptw_pkg::STATUS_W-1:0]     status
);

  mlptw_pkg::state_t state;
  mlptw_pkg::state_t state_next;

  logic [mlptw_pkg::ADDR_W-1:0]      clear_addr;
  logic                              root_present;
  logic                              root_present_next;
  logic [mlptw_pkg::FREE_W-1:0]      free_frame;
  logic [mlptw_pkg::FREE_W-1:0]      free_frame_next;
  logic [mlptw_pkg::FRAME_BITS-1:0]  cur_frame;
  logic [mlptw_pkg::FRAME_BITS-1:0]  cur_frame_next;
  logic [mlptw_pkg::VPN_W-1:0]       vpn;
  logic [mlptw_pkg::VPN_W-1:0]       vpn_next;
  logic [mlptw_pkg::OFFSET_BITS-1:0] page_offset;
  logic [mlptw_pkg::OFFSET_BITS-1:0] page_offset_next;
  logic                              is_map;
  logic                              is_map_next;
  logic [mlptw_pkg::LVL_W-1:0]       lvl;
  logic [mlptw_pkg::LVL_W-1:0]       lvl_next;
  logic                              done_next;
  logic [mlptw_pkg::PHYS_W-1:0]      phys_addr_next;
  mlptw_pkg::status_t                status_next;

  logic [mlptw_pkg::ENTRY_W-1:0]     entry_store [mlptw_pkg::STORE_DEPTH];
  logic [mlptw_pkg::ENTRY_W-1:0]     rd_entry;
  logic [mlptw_pkg::ADDR_W-1:0]      mem_addr;
  logic [mlptw_pkg::ADDR_W-1:0]      mem_waddr;
  logic [mlptw_pkg::ENTRY_W-1:0]     mem_wdata;
  logic                              mem_we;

  logic                              accept;
  logic                              entry_valid;
  logic [mlptw_pkg::FRAME_BITS-1:0]  entry_frame;
  logic                              pool_empty;
  logic                              last_level;
  logic                              clear_last;

  assign busy        = (state != mlptw_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign entry_valid = rd_entry[0];
  assign entry_frame = rd_entry[mlptw_pkg::ENTRY_W-1:1];
  assign pool_empty  = (free_frame >= mlptw_pkg::FREE_W'(mlptw_pkg::FRAME_COUNT));
  assign last_level  = (lvl == mlptw_pkg::LVL_W'(mlptw_pkg::LEVEL_COUNT - 1));
  assign clear_last  = (clear_addr == mlptw_pkg::ADDR_W'(mlptw_pkg::STORE_DEPTH - 1));
  assign mem_addr    = {cur_frame, vpn[mlptw_pkg::VPN_W-1 -: mlptw_pkg::IDX_BITS]};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_addr;
    mem_wdata = {free_frame[mlptw_pkg::FRAME_BITS-1:0], 1'b1};
    if (state == mlptw_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else if (state == mlptw_pkg::S_CHECK && !entry_valid && is_map && !pool_empty) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_store[mem_waddr] <= mem_wdata;
    end
    rd_entry <= entry_store[mem_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      mlptw_pkg::S_CLEAR: begin
        if (clear_last) begin
          state_next = mlptw_pkg::S_IDLE;
        end
      end
      mlptw_pkg::S_IDLE: begin
        if (accept) begin
          if (opcode == mlptw_pkg::OP_MAP) begin
            if (root_present || !pool_empty) begin
              state_next = mlptw_pkg::S_READ;
            end
          end else if (root_present) begin
            state_next = mlptw_pkg::S_READ;
          end
        end
      end
      mlptw_pkg::S_READ: begin
        state_next = mlptw_pkg::S_CHECK;
      end
      mlptw_pkg::S_CHECK: begin
        if (entry_valid || (is_map && !pool_empty)) begin
          state_next = last_level ? mlptw_pkg::S_IDLE : mlptw_pkg::S_READ;
        end else begin
          state_next = mlptw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mlptw_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    root_present_next = root_present;
    free_frame_next   = free_frame;
    cur_frame_next    = cur_frame;
    vpn_next          = vpn;
    page_offset_next  = page_offset;
    is_map_next       = is_map;
    lvl_next          = lvl;
    done_next         = 1'b0;
    phys_addr_next    = '0;
    status_next       = mlptw_pkg::STATUS_OK;
    case (state)
      mlptw_pkg::S_IDLE: begin
        if (accept) begin
          is_map_next      = (opcode == mlptw_pkg::OP_MAP);
          cur_frame_next   = '0;
          lvl_next         = '0;
          page_offset_next = virt_addr[mlptw_pkg::OFFSET_BITS-1:0];
          vpn_next = mlptw_pkg::VPN_W'(({{mlptw_pkg::VPN_W{1'b0}}, virt_addr})
                                        >> mlptw_pkg::OFFSET_BITS);
          if (!root_present) begin
            if (opcode == mlptw_pkg::OP_MAP) begin
              if (pool_empty) begin
                done_next   = 1'b1;
                status_next = mlptw_pkg::STATUS_NO_FRAME;
              end else begin
                root_present_next = 1'b1;
                cur_frame_next    = free_frame[mlptw_pkg::FRAME_BITS-1:0];
                free_frame_next   = free_frame + 1'b1;
              end
            end else begin
              done_next   = 1'b1;
              status_next = mlptw_pkg::STATUS_FAULT;
            end
          end
        end
      end
      mlptw_pkg::S_CHECK: begin
        vpn_next = vpn << mlptw_pkg::IDX_BITS;
        lvl_next = lvl + 1'b1;
        if (entry_valid) begin
          cur_frame_next = entry_frame;
          if (last_level) begin
            done_next = 1'b1;
            if (!is_map) begin
              phys_addr_next = mlptw_pkg::PHYS_W'({entry_frame, page_offset});
            end
          end
        end else if (is_map && !pool_empty) begin
          cur_frame_next  = free_frame[mlptw_pkg::FRAME_BITS-1:0];
          free_frame_next = free_frame + 1'b1;
          done_next       = last_level;
        end else begin
          done_next   = 1'b1;
          status_next = is_map ? mlptw_pkg::STATUS_NO_FRAME : mlptw_pkg::STATUS_FAULT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mlptw_pkg::S_CLEAR;
      clear_addr   <= '0;
      root_present <= 1'b0;
      free_frame   <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      clear_addr   <= clear_addr + 1'b1;
      root_present <= root_present_next;
      free_frame   <= free_frame_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_frame   <= cur_frame_next;
    vpn         <= vpn_next;
    page_offset <= page_offset_next;
    is_map      <= is_map_next;
    lvl         <= lvl_next;
    phys_addr   <= phys_addr_next;
    status      <= status_next;
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("Result shown without a request in progress.");

  assert property (@(posedge clk) disable iff (rst)
    free_frame <= mlptw_pkg::FREE_W'(mlptw_pkg::FRAME_COUNT))
    else $error("Frame allocator ran past the pool.");

  assert property (@(posedge clk) disable iff (rst)
    (done && status != mlptw_pkg::STATUS_OK) |-> (phys_addr == '0))
    else $error("Failed request returned a nonzero address.");

  assert property (@(posedge clk) disable iff (rst)
    (state == mlptw_pkg::S_CLEAR) |-> (!done && !root_present))
    else $error("Activity during the store clearing sweep.");

endmodule
